// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the fault protector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Assertion on clk_i, disabled while rst_ni is low.
`define MFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion on an explicit clock and active-low reset.
`define MFP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`else

`define MFP_ASSERT(lbl, prop, msg)
`define MFP_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ===== sv/mfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor fault protector package
// Widths, register indexes, fault codes and the configuration bundle.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned COUNT_BITS    = 8;
  localparam int unsigned PRESCALE_BITS = 8;
  localparam int unsigned PERSIST_BITS  = 8;
  localparam int unsigned FAULT_BITS    = 3;
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 12;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_CURRENT_LIMIT   = 3'd0,
    REG_OVER_VOLTAGE    = 3'd1,
    REG_UNDER_VOLTAGE   = 3'd2,
    REG_PERSIST_PERIODS = 3'd3,
    REG_TICK_PRESCALE   = 3'd4
  } cfg_reg_e;

  typedef enum logic [FAULT_BITS-1:0] {
    FAULT_NONE           = 3'd0,
    FAULT_HALL           = 3'd1,
    FAULT_UNDERVOLT      = 3'd2,
    FAULT_OVERVOLT       = 3'd3,
    FAULT_OVERCURRENT    = 3'd4,
    FAULT_HW_OVERCURRENT = 3'd5
  } fault_e;

  localparam logic [SAMPLE_BITS-1:0]   RST_CURRENT_LIMIT   = SAMPLE_BITS'(3103);
  localparam logic [SAMPLE_BITS-1:0]   RST_OVER_VOLTAGE    = SAMPLE_BITS'(3385);
  localparam logic [SAMPLE_BITS-1:0]   RST_UNDER_VOLTAGE   = SAMPLE_BITS'(1805);
  localparam logic [PERSIST_BITS-1:0]  RST_PERSIST_PERIODS = PERSIST_BITS'(10);
  localparam logic [PRESCALE_BITS-1:0] RST_TICK_PRESCALE   = PRESCALE_BITS'(20);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]   current_limit;
    logic [SAMPLE_BITS-1:0]   over_voltage_limit;
    logic [SAMPLE_BITS-1:0]   under_voltage_limit;
    logic [PERSIST_BITS-1:0]  persist_periods;
    logic [PRESCALE_BITS-1:0] tick_prescale;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] current_sample;
    logic [SAMPLE_BITS-1:0] voltage_sample;
    logic                   hw_overcurrent;
    logic                   hall_fault;
    logic                   motor_running;
  } tick_t;

endpackage

// ===== sv/mfp_if.sv =====
// ----------------------------------------------------------------------------
// Motor fault protector channels
// Valid/ready interfaces for ticks, results and configuration writes.
// ----------------------------------------------------------------------------
interface mfp_tick_if;
  logic                            valid;
  logic                            ready;
  logic [mfp_pkg::SAMPLE_BITS-1:0] current_sample;
  logic [mfp_pkg::SAMPLE_BITS-1:0] voltage_sample;
  logic                            hw_overcurrent;
  logic                            hall_fault;
  logic                            motor_running;

  modport source (output valid, current_sample, voltage_sample, hw_overcurrent,
                  hall_fault, motor_running, input ready);
  modport sink   (input valid, current_sample, voltage_sample, hw_overcurrent,
                  hall_fault, motor_running, output ready);
endinterface

interface mfp_result_if;
  logic                           valid;
  logic                           ready;
  logic [mfp_pkg::FAULT_BITS-1:0] fault_code;
  logic                           request_off;

  modport source (output valid, fault_code, request_off, input ready);
  modport sink   (input valid, fault_code, request_off, output ready);
endinterface

interface mfp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mfp_pkg::CFG_ADDR_BITS-1:0] addr;
  logic [mfp_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== sv/motor_fault_protector_core.sv =====
// ----------------------------------------------------------------------------
// Motor fault protector core
// Overcurrent / overvoltage protection with persistence countdowns.
//
//   Port      Dir  Contents
//   item_i    in   current_sample, voltage_sample, hw_overcurrent,
//                  hall_fault, motor_running
//   result_o  out  fault_code, request_off
//   cfg_i     in   addr (register index), data
//
// A tick is registered on acceptance, evaluated from the input register and its
// result registered; one tick is taken per cycle while no result is held back.
// The evaluation stage advances whenever the result register is empty or being
// taken in the same cycle; a result held back by the receiver stalls the input
// once the input register also holds a tick.
// Reset restores the register defaults and clears the prescaler, both
// countdowns and the latched fault; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_fault_protector_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfp_tick_if.sink      item_i,
  mfp_result_if.source  result_o,
  mfp_cfg_if.sink       cfg_i
);
  import mfp_pkg::*;

  cfg_t                  cfg;
  tick_t                 tick_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic [FAULT_BITS-1:0] code_q;
  logic                  request_off_q;
  logic [FAULT_BITS-1:0] eval_code;
  logic                  eval_request_off;
  logic                  advance;
  logic                  in_ready;

  assign advance  = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign item_i.ready = in_ready;

  mfp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mfp_fault_eval u_fault_eval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fire_i        (advance),
    .tick_i        (tick_q),
    .fault_code_o  (eval_code),
    .request_off_o (eval_request_off)
  );

  // Input stage: control under reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      tick_q.current_sample <= item_i.current_sample;
      tick_q.voltage_sample <= item_i.voltage_sample;
      tick_q.hw_overcurrent <= item_i.hw_overcurrent;
      tick_q.hall_fault     <= item_i.hall_fault;
      tick_q.motor_running  <= item_i.motor_running;
    end
  end

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q        <= eval_code;
      request_off_q <= eval_request_off;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.fault_code  = code_q;
  assign result_o.request_off = request_off_q;

  `MFP_ASSERT(a_tick_kept, in_valid_q && !advance |=> in_valid_q, "pending tick was dropped")
  `MFP_ASSERT(a_result_loaded, advance |=> out_valid_q, "evaluated tick produced no result")
  `MFP_ASSERT(a_off_needs_fault, out_valid_q && request_off_q |-> code_q != FAULT_BITS'(FAULT_NONE), "shutdown requested without a fault")

endmodule

// ===== sv/mfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the limits, persistence reload and prescale; written one at a time.
// ----------------------------------------------------------------------------
module mfp_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  mfp_cfg_if.sink        cfg_i,
  output mfp_pkg::cfg_t  cfg_o
);
  import mfp_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.addr))
        REG_CURRENT_LIMIT:   cfg_d.current_limit       = SAMPLE_BITS'(cfg_i.data);
        REG_OVER_VOLTAGE:    cfg_d.over_voltage_limit  = SAMPLE_BITS'(cfg_i.data);
        REG_UNDER_VOLTAGE:   cfg_d.under_voltage_limit = SAMPLE_BITS'(cfg_i.data);
        REG_PERSIST_PERIODS: cfg_d.persist_periods     = PERSIST_BITS'(cfg_i.data);
        REG_TICK_PRESCALE:   cfg_d.tick_prescale       = PRESCALE_BITS'(cfg_i.data);
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_limit       <= RST_CURRENT_LIMIT;
      cfg_q.over_voltage_limit  <= RST_OVER_VOLTAGE;
      cfg_q.under_voltage_limit <= RST_UNDER_VOLTAGE;
      cfg_q.persist_periods     <= RST_PERSIST_PERIODS;
      cfg_q.tick_prescale       <= RST_TICK_PRESCALE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/mfp_fault_eval.sv =====
// ----------------------------------------------------------------------------
// Fault evaluation
// Persistence countdowns, prescaler and latched fault code for one tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfp_fault_eval (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mfp_pkg::cfg_t                   cfg_i,
  input  logic                            fire_i,
  input  mfp_pkg::tick_t                  tick_i,
  output logic [mfp_pkg::FAULT_BITS-1:0]  fault_code_o,
  output logic                            request_off_o
);
  import mfp_pkg::*;

  logic [PRESCALE_BITS-1:0] presc_q, presc_d;
  logic [COUNT_BITS-1:0]    cur_cnt_q, cur_cnt_d;
  logic [COUNT_BITS-1:0]    vol_cnt_q, vol_cnt_d;
  fault_e                   fault_q, fault_d;

  logic [COUNT_BITS-1:0]    reload;
  logic [COUNT_BITS-1:0]    cur_mid, vol_mid;
  logic [PRESCALE_BITS:0]   presc_next;
  logic                     period_end;

  // Reload saturates at the largest count the countdown can hold.
  always_comb begin
    if (cfg_i.persist_periods > COUNT_MAX) begin
      reload = COUNT_MAX;
    end else begin
      reload = COUNT_BITS'(cfg_i.persist_periods);
    end
  end

  // Checks in priority order; a later check overwrites an earlier one.
  always_comb begin
    fault_d = fault_q;
    cur_mid = cur_cnt_q;
    vol_mid = vol_cnt_q;

    if (tick_i.hw_overcurrent) begin
      fault_d = FAULT_HW_OVERCURRENT;
    end
    if (tick_i.current_sample > cfg_i.current_limit) begin
      if (cur_cnt_q == '0) fault_d = FAULT_OVERCURRENT;
    end else begin
      cur_mid = reload;
    end

    if (tick_i.voltage_sample > cfg_i.over_voltage_limit) begin
      if (vol_cnt_q == '0) fault_d = FAULT_OVERVOLT;
    end else if (tick_i.voltage_sample > cfg_i.under_voltage_limit) begin
      vol_mid = reload;
    end else begin
      if (vol_cnt_q == '0) fault_d = FAULT_UNDERVOLT;
    end

    if (tick_i.hall_fault) begin
      fault_d = FAULT_HALL;
    end
  end

  assign presc_next = {1'b0, presc_q} + (PRESCALE_BITS+1)'(1);
  assign period_end = presc_next >= {1'b0, cfg_i.tick_prescale};

  always_comb begin
    presc_d   = period_end ? '0 : presc_next[PRESCALE_BITS-1:0];
    cur_cnt_d = cur_mid;
    vol_cnt_d = vol_mid;
    if (period_end) begin
      if (cur_mid != '0) cur_cnt_d = cur_mid - COUNT_BITS'(1);
      if (vol_mid != '0) vol_cnt_d = vol_mid - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q   <= '0;
      cur_cnt_q <= '0;
      vol_cnt_q <= '0;
      fault_q   <= FAULT_NONE;
    end else if (fire_i) begin
      presc_q   <= presc_d;
      cur_cnt_q <= cur_cnt_d;
      vol_cnt_q <= vol_cnt_d;
      fault_q   <= fault_d;
    end
  end

  assign fault_code_o  = FAULT_BITS'(fault_d);
  assign request_off_o = (fault_d != FAULT_NONE) && tick_i.motor_running;

  `MFP_ASSERT(a_fault_latches, fault_q != FAULT_NONE |=> fault_q != FAULT_NONE, "latched fault was cleared")
  `MFP_ASSERT(a_state_holds, !fire_i |=> $stable(presc_q) && $stable(cur_cnt_q) && $stable(vol_cnt_q) && $stable(fault_q), "state moved without a tick")
  `MFP_ASSERT(a_period_wrap, fire_i && period_end |=> presc_q == '0, "prescaler did not wrap at period end")

endmodule
